// ----- rtl/dspbb_pkg.sv -----
// ----------------------------------------------------------------------------
// dspbb_pkg: shared constants and types of the segment pair bitmask builder
// Window geometry, table layout, request codes and the window control and
// status structs.
// ----------------------------------------------------------------------------
`default_nettype none

package dspbb_pkg;

   // Geometry of keys, segments and shifts
   localparam int KEY_LEN   = 6;
   localparam int SEGMENTS  = 16;
   localparam int MAX_SHIFT = 3;
   localparam int ROWS      = 4096;

   localparam int WINDOW    = KEY_LEN * (SEGMENTS + 1) + MAX_SHIFT;
   localparam int LEVELS    = MAX_SHIFT + 1;
   localparam int HALF      = KEY_LEN / 2;

   // Widths of the item fields
   localparam int BASE_W    = 3;
   localparam int ROW_IN_W  = 12;
   localparam int LEVEL_W   = 2;
   localparam int MASK_W    = 16;

   // Derived widths
   localparam int ROW_W     = $clog2(ROWS);
   localparam int PACK_W    = 4 * HALF;
   localparam int ENTRY_W   = LEVELS * SEGMENTS;
   localparam int LAST_OFF  = SEGMENTS * KEY_LEN + MAX_SHIFT;
   localparam int OFF_W     = $clog2(LAST_OFF + 1);
   localparam int CNT_W     = $clog2(WINDOW + 1);

   // Request codes
   localparam logic REQ_PUSH = 1'b0;
   localparam logic REQ_READ = 1'b1;

   typedef logic [BASE_W-1:0]  base_type;
   typedef logic [ROW_W-1:0]   row_type;
   typedef logic [ENTRY_W-1:0] entry_type;

   // Window control from the sequencer
   typedef struct packed {
      logic     push;
      logic     step;
      base_type base;
   } win_ctrl_type;

   // Window status toward the sequencer
   typedef struct packed {
      logic    front_clean;
      logic    shift_clean;
      row_type row;
   } win_stat_type;

endpackage

`default_nettype wire

// ----- rtl/dspbb_req_if.sv -----
// ----------------------------------------------------------------------------
// dspbb_req_if: request channel
// Valid/ready channel carrying one push or read request item.
// ----------------------------------------------------------------------------
`default_nettype none

interface dspbb_req_if;
   logic                              valid;
   logic                              ready;
   logic                              req_type;
   dspbb_pkg::base_type               base;
   logic [dspbb_pkg::ROW_IN_W-1:0]    row;
   logic [dspbb_pkg::LEVEL_W-1:0]     indel_level;

   modport source (output valid, req_type, base, row, indel_level, input ready);
   modport sink   (input valid, req_type, base, row, indel_level, output ready);
endinterface

`default_nettype wire

// ----- rtl/dspbb_rsp_if.sv -----
// ----------------------------------------------------------------------------
// dspbb_rsp_if: result channel
// Valid/ready channel carrying one segment mask item.
// ----------------------------------------------------------------------------
`default_nettype none

interface dspbb_rsp_if;
   logic                            valid;
   logic                            ready;
   logic [dspbb_pkg::MASK_W-1:0]    segment_mask;

   modport source (output valid, segment_mask, input ready);
   modport sink   (input valid, segment_mask, output ready);
endinterface

`default_nettype wire

// ----- rtl/dna_segment_pair_bitmask_builder_unit.sv -----
// ----------------------------------------------------------------------------
// dna_segment_pair_bitmask_builder_unit: segment pair bitmask builder
// Slides a base window, scans every shifted key offset against the first key
// and ORs segment bits into a pair table; read requests return one row level.
//
//   channel | dir | payload                              | handshake
//   --------+-----+--------------------------------------+-------------
//   req_bus | in  | req_type, base, row, indel_level     | valid/ready
//   rsp_bus | out | segment_mask                         | valid/ready
//
// After reset a clearing pass zeroes the 4096-row table, one row a cycle;
// no item is taken until it ends. A push that fills the window, or comes
// on a full window, starts a scan: one read-modify-write slot per key
// offset (100 offsets) on the table memory, then a drain state. A read
// returns its item through the registered table read and then the output
// register or skid slot. A result waits in an output register and a skid
// slot; requests stall while the skid slot is occupied, while a scan or its
// drain state runs, and in the cycle after a read is accepted.
// ----------------------------------------------------------------------------
`default_nettype none

module dna_segment_pair_bitmask_builder_unit (
   input  wire logic clock,
   input  wire logic reset,
   dspbb_req_if.sink   req_bus,
   dspbb_rsp_if.source rsp_bus
);
   import dspbb_pkg::*;

   localparam logic [2:0] ST_CLEAR = 3'd0;
   localparam logic [2:0] ST_IDLE  = 3'd1;
   localparam logic [2:0] ST_SCAN  = 3'd2;
   localparam logic [2:0] ST_DRAIN = 3'd3;
   localparam logic [2:0] ST_READ  = 3'd4;

   localparam int CMP_W = OFF_W + 1;

   logic [2:0]         state_ff, state_in;
   row_type            clr_addr_ff, clr_addr_in;
   logic [CNT_W-1:0]   fill_ff, fill_in;
   logic [OFF_W-1:0]   off_ff, off_in;
   logic [LEVEL_W-1:0] level_ff, level_in;

   logic               s1_valid_ff, s1_valid_in;
   row_type            s1_row_ff;
   entry_type          s1_mask_ff;
   logic               lw_valid_ff;
   row_type            lw_row_ff;
   entry_type          lw_data_ff;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [MASK_W-1:0]  rsp_mask_ff, rsp_mask_in;
   logic               skid_valid_ff, skid_valid_in;
   logic [MASK_W-1:0]  skid_mask_ff, skid_mask_in;

   entry_type          table_mem [ROWS];
   entry_type          rdata_ff;
   row_type            rd_addr;
   logic               wr_en;
   row_type            wr_addr;
   entry_type          wr_data;
   entry_type          merged;

   entry_type          add_mask;
   logic               issue_active;
   logic [MASK_W-1:0]  read_mask;
   logic               accept;
   logic               rsp_free;

   win_ctrl_type       win_ctrl;
   win_stat_type       win_stat;

   dspbb_window u_window (
      .clock (clock),
      .ctrl  (win_ctrl),
      .stat  (win_stat)
   );

   assign accept   = req_bus.valid && req_bus.ready;
   assign rsp_free = !rsp_valid_ff || rsp_bus.ready;

   assign req_bus.ready     = (state_ff == ST_IDLE) && !skid_valid_ff;
   assign rsp_bus.valid     = rsp_valid_ff;
   assign rsp_bus.segment_mask = rsp_mask_ff;

   // Drive the window: push on an accepted base, step while scanning
   always_comb begin
      win_ctrl.push = accept && (req_bus.req_type == REQ_PUSH);
      win_ctrl.step = (state_ff == ST_SCAN);
      win_ctrl.base = req_bus.base;
   end

   // Build the bits to set for the current offset: segment i+1 at level k
   // when the offset lies within k of (i+1)*KEY_LEN
   always_comb begin
      add_mask = '0;
      for (int i = 0; i < SEGMENTS; i++) begin
         for (int k = 0; k < LEVELS; k++) begin
            if ((CMP_W'(off_ff) + CMP_W'(k) >= CMP_W'((i + 1) * KEY_LEN)) &&
                (CMP_W'(off_ff) <= CMP_W'((i + 1) * KEY_LEN + k))) begin
               add_mask[k*SEGMENTS + i] = 1'b1;
            end
         end
      end
   end

   assign issue_active = win_stat.front_clean && win_stat.shift_clean &&
                         (add_mask != '0);

   // Merge: forward the previous cycle's write when it hit the same row
   assign merged = ((lw_valid_ff && (lw_row_ff == s1_row_ff)) ? lw_data_ff : rdata_ff)
                   | s1_mask_ff;

   // Select the memory ports
   always_comb begin
      rd_addr = (state_ff == ST_SCAN) ? win_stat.row : ROW_W'(req_bus.row);
      if (state_ff == ST_CLEAR) begin
         wr_en   = 1'b1;
         wr_addr = clr_addr_ff;
         wr_data = '0;
      end else begin
         wr_en   = s1_valid_ff;
         wr_addr = s1_row_ff;
         wr_data = merged;
      end
   end

   // Pair table: one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (wr_en) begin
         table_mem[wr_addr] <= wr_data;
      end
      rdata_ff <= table_mem[rd_addr];
   end

   // Pick the requested level out of the row
   always_comb begin
      read_mask = '0;
      for (int k = 0; k < LEVELS; k++) begin
         if (level_ff == LEVEL_W'(k)) begin
            read_mask = MASK_W'(rdata_ff[k*SEGMENTS +: SEGMENTS]);
         end
      end
   end

   // Sequence clearing, scanning and reads
   always_comb begin
      state_in    = state_ff;
      clr_addr_in = clr_addr_ff;
      fill_in     = fill_ff;
      off_in      = off_ff;
      level_in    = level_ff;
      s1_valid_in = (state_ff == ST_SCAN) && issue_active;
      case (state_ff)
         ST_CLEAR: begin
            clr_addr_in = clr_addr_ff + 1'b1;
            if (clr_addr_ff == ROW_W'(ROWS - 1)) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (accept) begin
               if (req_bus.req_type == REQ_READ) begin
                  level_in = req_bus.indel_level;
                  state_in = ST_READ;
               end else begin
                  if (fill_ff != CNT_W'(WINDOW)) fill_in = fill_ff + 1'b1;
                  if (fill_ff >= CNT_W'(WINDOW - 1)) begin
                     off_in   = '0;
                     state_in = ST_SCAN;
                  end
               end
            end
         end
         ST_SCAN: begin
            off_in = off_ff + 1'b1;
            if (off_ff == OFF_W'(LAST_OFF)) state_in = ST_DRAIN;
         end
         ST_DRAIN: begin
            state_in = ST_IDLE;
         end
         ST_READ: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Hold results in the output register, spill to the skid slot when full
   always_comb begin
      rsp_valid_in  = rsp_valid_ff && !rsp_bus.ready;
      rsp_mask_in   = rsp_mask_ff;
      skid_valid_in = skid_valid_ff;
      skid_mask_in  = skid_mask_ff;
      if (state_ff == ST_READ) begin
         if (rsp_free) begin
            rsp_valid_in = 1'b1;
            rsp_mask_in  = read_mask;
         end else begin
            skid_valid_in = 1'b1;
            skid_mask_in  = read_mask;
         end
      end else if (skid_valid_ff && rsp_free) begin
         rsp_valid_in  = 1'b1;
         rsp_mask_in   = skid_mask_ff;
         skid_valid_in = 1'b0;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         clr_addr_ff   <= '0;
         fill_ff       <= '0;
         off_ff        <= '0;
         level_ff      <= '0;
         s1_valid_ff   <= 1'b0;
         lw_valid_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clr_addr_ff   <= clr_addr_in;
         fill_ff       <= fill_in;
         off_ff        <= off_in;
         level_ff      <= level_in;
         s1_valid_ff   <= s1_valid_in;
         lw_valid_ff   <= s1_valid_ff;
         rsp_valid_ff  <= rsp_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      s1_row_ff    <= win_stat.row;
      s1_mask_ff   <= add_mask;
      lw_row_ff    <= s1_row_ff;
      lw_data_ff   <= merged;
      rsp_mask_ff  <= rsp_mask_in;
      skid_mask_ff <= skid_mask_in;
   end

endmodule

`default_nettype wire

// ----- rtl/dspbb_window.sv -----
// ----------------------------------------------------------------------------
// dspbb_window: base window and scan line
// Holds the sliding base window and a scan copy that moves one position per
// step, so the shifted key always sits at the scan line's first taps.
// ----------------------------------------------------------------------------
`default_nettype none

module dspbb_window (
   input  wire logic                    clock,
   input  wire dspbb_pkg::win_ctrl_type ctrl,
   output dspbb_pkg::win_stat_type      stat
);
   import dspbb_pkg::*;

   base_type window_ff [WINDOW];
   base_type window_in [WINDOW];
   base_type scan_ff   [WINDOW];
   base_type scan_in   [WINDOW];
   logic [PACK_W-1:0] packed_row;

   // Shift the new base in at the young end; reload or advance the scan line
   always_comb begin
      for (int p = 0; p < WINDOW; p++) begin
         window_in[p] = window_ff[p];
         scan_in[p]   = scan_ff[p];
      end
      if (ctrl.push) begin
         for (int p = 0; p < WINDOW - 1; p++) begin
            window_in[p] = window_ff[p+1];
         end
         window_in[WINDOW-1] = ctrl.base;
         for (int p = 0; p < WINDOW; p++) begin
            scan_in[p] = window_in[p];
         end
      end else if (ctrl.step) begin
         for (int p = 0; p < WINDOW - 1; p++) begin
            scan_in[p] = scan_ff[p+1];
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int p = 0; p < WINDOW; p++) begin
         window_ff[p] <= window_in[p];
         scan_ff[p]   <= scan_in[p];
      end
   end

   // Flag keys holding an unknown base (any code from N up), then pack front
   // halves, first key first, first base most significant
   always_comb begin
      stat.front_clean = 1'b1;
      stat.shift_clean = 1'b1;
      packed_row = '0;
      for (int p = 0; p < KEY_LEN; p++) begin
         if (window_ff[p][2]) stat.front_clean = 1'b0;
         if (scan_ff[p][2])   stat.shift_clean = 1'b0;
      end
      for (int p = 0; p < HALF; p++) begin
         packed_row[PACK_W-1-2*p -: 2] = window_ff[p][1:0];
         packed_row[2*HALF-1-2*p -: 2] = scan_ff[p][1:0];
      end
      stat.row = packed_row[ROW_W-1:0];
   end

endmodule

`default_nettype wire
